// ----- rtl/core/psa_pkg.sv -----
// ----------------------------------------------------------------------------
// Slot pool allocator package
// Shared types, command and status codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package psa_pkg;

  // Default number of slots in the pool
  localparam int unsigned PoolSlotsDef = 16;
  // Most auto releases reported for one tick
  localparam int unsigned MaxResults   = 16;
  localparam int unsigned ResCntW      = $clog2(MaxResults + 1);

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAX_POOL  = 2'd0,
    CFG_PREWARM   = 2'd1,
    CFG_TIMEOUT   = 2'd2,
    CFG_EVICT     = 2'd3
  } cfg_idx_e;

  localparam logic [4:0]  MaxPoolRst = 5'd16;
  localparam logic [4:0]  PrewarmRst = 5'd0;
  localparam logic [15:0] TimeoutRst = 16'd0;
  localparam logic [1:0]  EvictRst   = 2'd0;

  // Eviction modes
  typedef enum logic [1:0] {
    EVICT_NONE   = 2'd0,
    EVICT_OLDEST = 2'd1,
    EVICT_PRIO   = 2'd2,
    EVICT_RSVD   = 2'd3
  } evict_e;

  // Commands
  typedef enum logic [2:0] {
    CMD_INIT        = 3'd0,
    CMD_ACQUIRE     = 3'd1,
    CMD_RELEASE     = 3'd2,
    CMD_RELEASE_ALL = 3'd3,
    CMD_TICK        = 3'd4
  } cmd_e;

  // Result status codes
  typedef enum logic [2:0] {
    STS_REUSED       = 3'd0,
    STS_CREATED      = 3'd1,
    STS_EVICTED      = 3'd2,
    STS_FULL         = 3'd3,
    STS_RELEASED     = 3'd4,
    STS_NOT_ACTIVE   = 3'd5,
    STS_NONE_EXPIRED = 3'd6,
    STS_INITIALIZED  = 3'd7
  } status_e;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [15:0] priority_req;
    logic [3:0]         slot_id;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [4:0]  freed_count;
    logic [4:0]  live_count;
    logic [4:0]  idle_count;
    logic [15:0] eviction_total;
    logic        last;
  } out_word_t;

  // Per-slot record kept in memory
  typedef struct packed {
    logic signed [15:0] prio;
    logic [31:0]        stamp;
  } slot_rec_t;

endpackage

// ----- rtl/core/psa_slot_mem.sv -----
// ----------------------------------------------------------------------------
// Slot record memory
// Priority and acquire stamp per slot, one write and one registered read port.
// ----------------------------------------------------------------------------
module psa_slot_mem #(
  parameter int unsigned Slots = psa_pkg::PoolSlotsDef,
  parameter int unsigned AddrW = $clog2(Slots)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  psa_pkg::slot_rec_t   wrec_i,
  input  logic [AddrW-1:0]     raddr_i,
  output psa_pkg::slot_rec_t   rrec_o
);
  import psa_pkg::*;

  slot_rec_t mem_q [Slots];
  slot_rec_t rrec_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wrec_i;
    end
    rrec_q <= mem_q[raddr_i];
  end

  assign rrec_o = rrec_q;

endmodule

// ----- rtl/core/pool_slot_allocator_with_eviction_top.sv -----
// ----------------------------------------------------------------------------
// Slot pool allocator with eviction
// Acquire, release and timed auto release of pool slots with eviction by age
// or priority, built around one scan unit that visits a slot per cycle.
// ----------------------------------------------------------------------------
// Sequence: init, release and release all load their result from the execute state; acquire
// goes through setup, one scan pass over the slot memory read port, and resolve. Tick
// with a zero timeout goes straight to emit, else it scans first, then emits one word
// per freed slot as the walk reaches it, or one none-expired word.
// Commands: the next command is taken once the block is idle again after its last result
// loads; output stalls add. Reset clears control, restores register defaults, not slot memory.
module pool_slot_allocator_with_eviction_top #(
  parameter int unsigned POOL_SLOTS = psa_pkg::PoolSlotsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  psa_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output psa_pkg::out_word_t out_word_o
);
  import psa_pkg::*;

  localparam int unsigned IdxW = $clog2(POOL_SLOTS);
  localparam int unsigned CntW = $clog2(POOL_SLOTS + 1);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_EXEC    = 5'b00010,
    ST_SCAN    = 5'b00100,
    ST_RESOLVE = 5'b01000,
    ST_EMIT    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Configuration
  logic [4:0]  max_pool_q, prewarm_q;
  logic [15:0] timeout_q;
  logic [1:0]  mode_q;

  // Latched command
  logic [2:0]         cmd_q, cmd_d;
  logic signed [15:0] prio_q, prio_d;
  logic [3:0]         sid_q, sid_d;

  // Pool state
  logic [POOL_SLOTS-1:0] active_q, active_d;
  logic [CntW-1:0]       created_q, created_d;
  logic [CntW-1:0]       live_q, live_d;
  logic [31:0]           time_q, time_d;
  logic [15:0]           evict_q, evict_d;

  // Scan unit
  logic [CntW-1:0]    idx_q, idx_d;
  logic               p_vld_q, p_vld_d;
  logic [IdxW-1:0]    p_idx_q, p_idx_d;
  logic               free_fnd_q, free_fnd_d;
  logic [IdxW-1:0]    free_idx_q, free_idx_d;
  logic               vic_fnd_q, vic_fnd_d;
  logic [IdxW-1:0]    vic_idx_q, vic_idx_d;
  logic [31:0]        vic_age_q, vic_age_d;
  logic signed [15:0] vic_prio_q, vic_prio_d;
  logic [POOL_SLOTS-1:0] mask_q, mask_d;
  logic [ResCntW-1:0]    n_q, n_d;
  logic [ResCntW-1:0]    em_q, em_d;

  // Memory port
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  slot_rec_t       mem_wrec;
  slot_rec_t       mem_rrec;

  // Output register
  logic      out_valid_q;
  out_word_t out_word_q;
  out_word_t out_d;
  logic      out_load;
  logic      out_free;

  logic [CntW-1:0] lim;
  logic [31:0]     age;
  logic            issue;
  logic            better;

  assign lim      = (int'(max_pool_q) < int'(POOL_SLOTS)) ? CntW'(max_pool_q)
                                                           : CntW'(POOL_SLOTS);
  assign age      = time_q - mem_rrec.stamp;
  assign issue    = (idx_q < created_q);
  assign out_free = !out_valid_q || !out_stall_i;

  // Victim preference: older wins, or lower priority then older
  assign better = (mode_q == EVICT_OLDEST) ? (age > vic_age_q)
                : ((mem_rrec.prio < vic_prio_q) ||
                   ((mem_rrec.prio == vic_prio_q) && (age > vic_age_q)));

  psa_slot_mem #(
    .Slots (POOL_SLOTS),
    .AddrW (IdxW)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wrec_i  (mem_wrec),
    .raddr_i (idx_q[IdxW-1:0]),
    .rrec_o  (mem_rrec)
  );

  always_comb begin
    logic            pick_ok;
    logic [IdxW-1:0] pick;
    logic [IdxW-1:0] sid_idx;

    pick_ok = 1'b0;
    pick    = '0;
    sid_idx = IdxW'(sid_q);

    state_d    = state_q;
    cmd_d      = cmd_q;
    prio_d     = prio_q;
    sid_d      = sid_q;
    active_d   = active_q;
    created_d  = created_q;
    live_d     = live_q;
    time_d     = time_q;
    evict_d    = evict_q;
    idx_d      = idx_q;
    p_vld_d    = p_vld_q;
    p_idx_d    = p_idx_q;
    free_fnd_d = free_fnd_q;
    free_idx_d = free_idx_q;
    vic_fnd_d  = vic_fnd_q;
    vic_idx_d  = vic_idx_q;
    vic_age_d  = vic_age_q;
    vic_prio_d = vic_prio_q;
    mask_d     = mask_q;
    n_d        = n_q;
    em_d       = em_q;

    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wrec  = '{prio: prio_q, stamp: time_q};

    out_load = 1'b0;
    out_d    = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = in_word_i.command;
          prio_d  = in_word_i.priority_req;
          sid_d   = in_word_i.slot_id;
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (cmd_q)
          CMD_INIT: begin
            if (out_free) begin
              active_d  = '0;
              created_d = (int'(prewarm_q) < int'(lim)) ? CntW'(prewarm_q) : lim;
              live_d    = '0;
              evict_d   = '0;
              out_load  = 1'b1;
              out_d.status = STS_INITIALIZED;
              out_d.last   = 1'b1;
              state_d   = ST_IDLE;
            end
          end
          CMD_ACQUIRE: begin
            idx_d      = '0;
            p_vld_d    = 1'b0;
            free_fnd_d = 1'b0;
            vic_fnd_d  = 1'b0;
            state_d    = ST_SCAN;
          end
          CMD_RELEASE: begin
            if (out_free) begin
              out_load     = 1'b1;
              out_d.slot   = sid_q;
              out_d.last   = 1'b1;
              if ((int'(sid_q) < int'(created_q)) && active_q[sid_idx]) begin
                active_d[sid_idx] = 1'b0;
                live_d       = live_q - CntW'(1);
                out_d.status = STS_RELEASED;
              end else begin
                out_d.status = STS_NOT_ACTIVE;
              end
              state_d = ST_IDLE;
            end
          end
          CMD_RELEASE_ALL: begin
            if (out_free) begin
              // live count always equals the number of active slots
              out_load          = 1'b1;
              out_d.status      = STS_RELEASED;
              out_d.freed_count = 5'(live_q);
              out_d.last        = 1'b1;
              active_d          = '0;
              live_d            = '0;
              state_d           = ST_IDLE;
            end
          end
          CMD_TICK: begin
            time_d  = time_q + 32'd1;
            n_d     = '0;
            em_d    = '0;
            mask_d  = '0;
            idx_d   = '0;
            p_vld_d = 1'b0;
            state_d = (timeout_q != 16'd0) ? ST_SCAN : ST_EMIT;
          end
          default: begin
            // drop unknown commands without a result
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_SCAN: begin
        // issue one memory read per cycle, evaluate it on the next
        p_vld_d = issue;
        p_idx_d = idx_q[IdxW-1:0];
        if (issue) begin
          idx_d = idx_q + CntW'(1);
        end
        if (p_vld_q) begin
          if (cmd_q == CMD_TICK) begin
            if (active_q[p_idx_q] && (age >= {16'd0, timeout_q}) &&
                (n_q < ResCntW'(MaxResults))) begin
              active_d[p_idx_q] = 1'b0;
              live_d            = live_q - CntW'(1);
              mask_d[p_idx_q]   = 1'b1;
              n_d               = n_q + ResCntW'(1);
            end
          end else begin
            if (!active_q[p_idx_q]) begin
              if (!free_fnd_q) begin
                free_fnd_d = 1'b1;
                free_idx_d = p_idx_q;
              end
            end else if (!vic_fnd_q || better) begin
              vic_fnd_d  = 1'b1;
              vic_idx_d  = p_idx_q;
              vic_age_d  = age;
              vic_prio_d = mem_rrec.prio;
            end
          end
        end
        if (!issue && !p_vld_q) begin
          idx_d   = '0;
          state_d = (cmd_q == CMD_TICK) ? ST_EMIT : ST_RESOLVE;
        end
      end

      ST_RESOLVE: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_d.last = 1'b1;
          if (free_fnd_q) begin
            pick_ok      = 1'b1;
            pick         = free_idx_q;
            live_d       = live_q + CntW'(1);
            out_d.status = STS_REUSED;
          end else if (created_q < lim) begin
            pick_ok      = 1'b1;
            pick         = IdxW'(created_q);
            created_d    = created_q + CntW'(1);
            live_d       = live_q + CntW'(1);
            out_d.status = STS_CREATED;
          end else if (((mode_q == EVICT_OLDEST) || (mode_q == EVICT_PRIO)) &&
                       vic_fnd_q) begin
            // victim stays active for the new owner; live count holds
            pick_ok      = 1'b1;
            pick         = vic_idx_q;
            if (evict_q != 16'hFFFF) begin
              evict_d = evict_q + 16'd1;
            end
            out_d.status = STS_EVICTED;
          end else begin
            out_d.status = STS_FULL;
          end
          if (pick_ok) begin
            active_d[pick] = 1'b1;
            mem_we         = 1'b1;
            mem_waddr      = pick;
            out_d.slot     = 4'(pick);
          end
          state_d = ST_IDLE;
        end
      end

      ST_EMIT: begin
        if (n_q == '0) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_d.status = STS_NONE_EXPIRED;
            out_d.last   = 1'b1;
            state_d      = ST_IDLE;
          end
        end else if (mask_q[idx_q[IdxW-1:0]]) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_d.status = STS_RELEASED;
            out_d.slot   = 4'(idx_q);
            out_d.last   = ((em_q + ResCntW'(1)) == n_q);
            em_d         = em_q + ResCntW'(1);
            idx_d        = idx_q + CntW'(1);
            if (out_d.last) begin
              state_d = ST_IDLE;
            end
          end
        end else begin
          idx_d = idx_q + CntW'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // counts reported are the ones after the step
    out_d.live_count     = 5'(live_d);
    out_d.idle_count     = 5'(created_d - live_d);
    out_d.eviction_total = evict_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pool_q <= MaxPoolRst;
      prewarm_q  <= PrewarmRst;
      timeout_q  <= TimeoutRst;
      mode_q     <= EvictRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_POOL: max_pool_q <= cfg_data_i[4:0];
        CFG_PREWARM:  prewarm_q  <= cfg_data_i[4:0];
        CFG_TIMEOUT:  timeout_q  <= cfg_data_i;
        CFG_EVICT:    mode_q     <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      created_q   <= '0;
      live_q      <= '0;
      time_q      <= '0;
      evict_q     <= '0;
      idx_q       <= '0;
      p_vld_q     <= 1'b0;
      free_fnd_q  <= 1'b0;
      vic_fnd_q   <= 1'b0;
      mask_q      <= '0;
      n_q         <= '0;
      em_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      active_q   <= active_d;
      created_q  <= created_d;
      live_q     <= live_d;
      time_q     <= time_d;
      evict_q    <= evict_d;
      idx_q      <= idx_d;
      p_vld_q    <= p_vld_d;
      free_fnd_q <= free_fnd_d;
      vic_fnd_q  <= vic_fnd_d;
      mask_q     <= mask_d;
      n_q        <= n_d;
      em_q       <= em_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    prio_q     <= prio_d;
    sid_q      <= sid_d;
    p_idx_q    <= p_idx_d;
    free_idx_q <= free_idx_d;
    vic_idx_q  <= vic_idx_d;
    vic_age_q  <= vic_age_d;
    vic_prio_q <= vic_prio_d;
    if (out_load) begin
      out_word_q <= out_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slot pool allocator testbench
// Drives pool commands through the valid/stall input channel under several
// register settings, keeps its own copy of the pool to work out the replies
// each command must produce, and compares every reply word field by field
// while, in most phases, both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module testbench;
  import psa_pkg::*;

  localparam int unsigned PoolSlots   = PoolSlotsDef;
  localparam int          DrainCycles = 64;
  localparam int          PhaseItems  = 40;
  localparam int          CmdSpareLo  = CMD_TICK + 1;
  localparam int          CmdSpareHi  = 7;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        cfg_we_i   = 1'b0;
  logic [1:0]  cfg_idx_i  = CFG_MAX_POOL;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_word_t    in_word_i  = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_word_o;

  pool_slot_allocator_with_eviction_top #(
    .POOL_SLOTS(PoolSlots)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always #4 clk_i = ~clk_i;

  // Pool shadow state and register copies
  logic               pool_active [PoolSlots];
  logic signed [15:0] pool_prio   [PoolSlots];
  logic [31:0]        pool_stamp  [PoolSlots];
  int unsigned        pool_created;
  int unsigned        pool_live;
  logic [31:0]        pool_clock;
  logic [15:0]        pool_evictions;
  logic [4:0]         reg_max_pool;
  logic [4:0]         reg_prewarm;
  logic [15:0]        reg_timeout;
  logic [1:0]         reg_mode;

  in_word_t  commands_pending [$];
  out_word_t replies_due      [$];
  out_word_t oldest_reply;
  int        commands_queued = 0;
  int        commands_taken  = 0;
  int        error_count     = 0;
  bit        idle_on         = 1'b1;
  int        send_gap        = 0;
  int        stall_left      = 0;

  task automatic flag_error(input string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    error_count++;
  endtask

  // Work out the reply words of one accepted command and update the shadow pool
  task automatic pool_apply(input in_word_t w);
    out_word_t   batch [$];
    out_word_t   r;
    int          i, k, pick, best;
    int unsigned lim, freed;
    logic [31:0] age, best_age;
    status_e     st;
    lim = (reg_max_pool < PoolSlots) ? reg_max_pool : PoolSlots;
    r = '0;
    case (w.command)
      CMD_INIT: begin
        for (i = 0; i < PoolSlots; i++) pool_active[i] = 1'b0;
        pool_created = (reg_prewarm < lim) ? reg_prewarm : lim;
        pool_live = 0;
        pool_evictions = '0;
        r.status = STS_INITIALIZED;
        batch.push_back(r);
      end
      CMD_ACQUIRE: begin
        pick = -1;
        st = STS_REUSED;
        for (i = 0; i < pool_created; i++)
          if (pick < 0 && !pool_active[i]) pick = i;
        if (pick < 0 && pool_created < lim) begin
          pick = pool_created;
          pool_created++;
          st = STS_CREATED;
        end
        if (pick < 0 && (reg_mode == EVICT_OLDEST || reg_mode == EVICT_PRIO)) begin
          best = -1;
          for (i = 0; i < pool_created; i++) begin
            if (pool_active[i]) begin
              if (best < 0) begin
                best = i;
              end else begin
                age = pool_clock - pool_stamp[i];
                best_age = pool_clock - pool_stamp[best];
                if (reg_mode == EVICT_OLDEST) begin
                  if (age > best_age) best = i;
                end else if (pool_prio[i] < pool_prio[best] ||
                             (pool_prio[i] == pool_prio[best] && age > best_age)) begin
                  best = i;
                end
              end
            end
          end
          if (best >= 0) begin
            pick = best;
            pool_active[best] = 1'b0;
            pool_live--;
            if (pool_evictions != 16'hFFFF) pool_evictions++;
            st = STS_EVICTED;
          end
        end
        if (pick < 0) begin
          r.status = STS_FULL;
        end else begin
          pool_active[pick] = 1'b1;
          pool_prio[pick] = w.priority_req;
          pool_stamp[pick] = pool_clock;
          pool_live++;
          r.status = st;
          r.slot = 4'(pick);
        end
        batch.push_back(r);
      end
      CMD_RELEASE: begin
        r.slot = w.slot_id;
        if (w.slot_id < pool_created && pool_active[w.slot_id]) begin
          pool_active[w.slot_id] = 1'b0;
          pool_live--;
          r.status = STS_RELEASED;
        end else begin
          r.status = STS_NOT_ACTIVE;
        end
        batch.push_back(r);
      end
      CMD_RELEASE_ALL: begin
        freed = 0;
        for (i = 0; i < pool_created; i++) begin
          if (pool_active[i]) begin
            pool_active[i] = 1'b0;
            freed++;
          end
        end
        pool_live = 0;
        r.status = STS_RELEASED;
        r.freed_count = 5'(freed);
        batch.push_back(r);
      end
      CMD_TICK: begin
        pool_clock++;
        if (reg_timeout != '0) begin
          for (i = 0; i < pool_created; i++) begin
            if (batch.size() < MaxResults && pool_active[i] &&
                pool_clock - pool_stamp[i] >= reg_timeout) begin
              pool_active[i] = 1'b0;
              pool_live--;
              r.status = STS_RELEASED;
              r.slot = 4'(i);
              batch.push_back(r);
            end
          end
        end
        if (batch.size() == 0) begin
          r.status = STS_NONE_EXPIRED;
          batch.push_back(r);
        end
      end
      default: ;
    endcase
    // counts in every word reflect the pool after the whole command
    for (k = 0; k < batch.size(); k++) begin
      batch[k].live_count = 5'(pool_live);
      batch[k].idle_count = 5'(pool_created - pool_live);
      batch[k].eviction_total = pool_evictions;
      batch[k].last = (k == batch.size() - 1);
      replies_due.push_back(batch[k]);
    end
  endtask

  // Input driver: present queued words, hold while stalled, idle in bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i <= '0;
      send_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        pool_apply(in_word_i);
        commands_taken++;
        if (idle_on && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 12);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (commands_pending.size() > 0) begin
          in_valid_i <= 1'b1;
          in_word_i <= commands_pending.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compare each accepted reply word, stall in bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (replies_due.size() == 0) begin
          flag_error($sformatf("reply word with none expected: %h", out_word_o));
        end else begin
          oldest_reply = replies_due.pop_front();
          if (out_word_o.status !== oldest_reply.status)
            flag_error($sformatf("status got %0d want %0d",
                                 out_word_o.status, oldest_reply.status));
          if (out_word_o.slot !== oldest_reply.slot)
            flag_error($sformatf("slot got %0d want %0d",
                                 out_word_o.slot, oldest_reply.slot));
          if (out_word_o.freed_count !== oldest_reply.freed_count)
            flag_error($sformatf("freed_count got %0d want %0d",
                                 out_word_o.freed_count, oldest_reply.freed_count));
          if (out_word_o.live_count !== oldest_reply.live_count)
            flag_error($sformatf("live_count got %0d want %0d",
                                 out_word_o.live_count, oldest_reply.live_count));
          if (out_word_o.idle_count !== oldest_reply.idle_count)
            flag_error($sformatf("idle_count got %0d want %0d",
                                 out_word_o.idle_count, oldest_reply.idle_count));
          if (out_word_o.eviction_total !== oldest_reply.eviction_total)
            flag_error($sformatf("eviction_total got %0d want %0d",
                                 out_word_o.eviction_total, oldest_reply.eviction_total));
          if (out_word_o.last !== oldest_reply.last)
            flag_error($sformatf("last got %0b want %0b",
                                 out_word_o.last, oldest_reply.last));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send(input logic [2:0] cmd, input logic [15:0] prio, input logic [3:0] sid);
    in_word_t w;
    w.command = cmd;
    w.priority_req = prio;
    w.slot_id = sid;
    commands_pending.push_back(w);
    commands_queued++;
  endtask

  // Wait until every word is taken and every reply is in, then let the block settle
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (commands_taken != commands_queued || replies_due.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    case (idx)
      CFG_MAX_POOL: reg_max_pool = value[4:0];
      CFG_PREWARM:  reg_prewarm = value[4:0];
      CFG_TIMEOUT:  reg_timeout = value;
      CFG_EVICT:    reg_mode = value[1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int max_pool, input int prewarm, input int timeout,
                                input evict_e mode);
    wait_quiet();
    write_reg(CFG_MAX_POOL, 16'(max_pool));
    write_reg(CFG_PREWARM, 16'(prewarm));
    write_reg(CFG_TIMEOUT, 16'(timeout));
    write_reg(CFG_EVICT, 16'(mode));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Limit on the whole run
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int     ph, made, roll, n, j;
    int     max_tbl [8];
    int     pre_tbl [8];
    int     tmo_tbl [8];
    evict_e mode_tbl [8];
    logic [15:0] prio;
    logic [3:0]  sid;

    max_tbl  = '{16, 1, 4, 16, 8, 2, 16, 12};
    pre_tbl  = '{16, 0, 3, 8, 16, 0, 5, 1};
    tmo_tbl  = '{4, 1, 5, 65535, 3, 0, 1, 8};
    mode_tbl = '{EVICT_NONE, EVICT_OLDEST, EVICT_PRIO, EVICT_OLDEST,
                 EVICT_PRIO, EVICT_NONE, EVICT_PRIO, EVICT_OLDEST};

    for (j = 0; j < PoolSlots; j++) begin
      pool_active[j] = 1'b0;
      pool_prio[j] = '0;
      pool_stamp[j] = '0;
    end
    pool_created = 0;
    pool_live = 0;
    pool_clock = '0;
    pool_evictions = '0;
    reg_max_pool = MaxPoolRst;
    reg_prewarm = PrewarmRst;
    reg_timeout = TimeoutRst;
    reg_mode = EvictRst;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Two slots, no eviction: create, full, release twice, reuse, spare codes
    apply_settings(2, 0, 0, EVICT_NONE);
    send(CMD_INIT, 16'h0000, 4'h0);
    send(CMD_ACQUIRE, 16'h7FFF, 4'h0);
    send(CMD_ACQUIRE, 16'h8000, 4'h0);
    send(CMD_ACQUIRE, 16'h0000, 4'h0);
    send(CMD_RELEASE, 16'h0000, 4'h1);
    send(CMD_RELEASE, 16'h0000, 4'h1);
    send(CMD_RELEASE, 16'h0000, 4'hF);
    send(CMD_ACQUIRE, 16'hFFFF, 4'hF);
    send(CMD_TICK, 16'h0000, 4'h0);
    send(CMD_RELEASE_ALL, 16'h0000, 4'h0);
    for (j = CmdSpareLo; j <= CmdSpareHi; j++) send(3'(j), 16'hFFFF, 4'hF);

    // Prewarm capped by the limit, oldest eviction with a tie, timed release
    apply_settings(3, 16, 2, EVICT_OLDEST);
    send(CMD_INIT, 16'h0000, 4'h0);
    send(CMD_ACQUIRE, 16'd10, 4'h0);
    send(CMD_ACQUIRE, 16'd20, 4'h0);
    send(CMD_TICK, 16'h0000, 4'h0);
    send(CMD_ACQUIRE, 16'd30, 4'h0);
    send(CMD_ACQUIRE, 16'd40, 4'h0);
    send(CMD_TICK, 16'h0000, 4'h0);

    // Priority mode, then a limit lowered below the slots already created forces priority eviction
    apply_settings(16, 0, 0, EVICT_PRIO);
    send(CMD_ACQUIRE, 16'd100, 4'h0);
    send(CMD_ACQUIRE, 16'd100, 4'h0);
    send(CMD_ACQUIRE, 16'hFFFB, 4'h0);
    apply_settings(1, 0, 0, EVICT_PRIO);
    send(CMD_ACQUIRE, 16'h8000, 4'h0);
    send(CMD_ACQUIRE, 16'h0000, 4'h0);
    send(CMD_RELEASE_ALL, 16'h0000, 4'h0);

    for (ph = 0; ph < 8; ph++) begin
      apply_settings(max_tbl[ph], pre_tbl[ph], tmo_tbl[ph], mode_tbl[ph]);
      idle_on = (ph != 3) && (ph < 6);
      made = 0;
      // odd phases keep the pool left by the previous settings
      if (ph % 2 == 0) begin
        send(CMD_INIT, 16'(16'($urandom)), 4'($urandom));
        made++;
      end
      while (made < PhaseItems) begin
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
          n = $urandom_range(1, 6);
          repeat (n) begin
            prio = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 6) - 3);
            send(CMD_ACQUIRE, prio, 4'($urandom));
          end
          made += n;
        end else if (roll < 65) begin
          n = $urandom_range(1, 4);
          repeat (n) send(CMD_TICK, 16'($urandom), 4'($urandom));
          made += n;
        end else if (roll < 82) begin
          sid = $urandom_range(0, 1) ? 4'($urandom_range(0, max_tbl[ph] - 1))
                                     : 4'($urandom_range(0, 15));
          send(CMD_RELEASE, 16'($urandom), sid);
          made++;
        end else if (roll < 87) begin
          send(CMD_RELEASE_ALL, 16'($urandom), 4'($urandom));
          made++;
        end else if (roll < 90) begin
          send(CMD_INIT, 16'($urandom), 4'($urandom));
          made++;
        end else if (roll < 95) begin
          // fill the pool, then let a tick expire as much as it can
          repeat (PoolSlots) send(CMD_ACQUIRE, 16'($urandom), 4'($urandom));
          send(CMD_TICK, 16'($urandom), 4'($urandom));
          made += PoolSlots + 1;
        end else begin
          send(3'($urandom_range(CmdSpareLo, CmdSpareHi)), 16'($urandom), 4'($urandom));
          made++;
        end
      end
    end

    wait_quiet();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
